// File: rtl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and codes for the set-associative cache simulator with LRU
// replacement.
// ----------------------------------------------------------------------------
package sacl_pkg;

  typedef enum logic [1:0] {
    CMD_INSTR  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_STORE  = 2'd2,
    CMD_MODIFY = 2'd3
  } sacl_cmd_t;

  localparam logic [1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BITS  = 2'd1;
  localparam logic [1:0] CFG_WAYS_IN_USE = 2'd2;

  typedef struct packed {
    logic hit;
    logic fill;
    logic evict;
  } sacl_outcome_t;

endpackage

// File: rtl/sacl_ram.sv
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/sacl_way_sel.sv
// ----------------------------------------------------------------------------
// sacl_way_sel
// Looks up one set row: finds a hit, a free way or the LRU victim, and
// builds the updated valid bits, tags and age ranks of the row.
// ----------------------------------------------------------------------------
module sacl_way_sel
  import sacl_pkg::*;
#(
  parameter int WAYS   = 4,
  parameter int TAG_W  = 30,
  parameter int WI_W   = (WAYS > 1) ? $clog2(WAYS) : 1,
  parameter int WN_W   = $clog2(WAYS + 1)
) (
  input  logic [WN_W-1:0]             n,
  input  logic [WAYS-1:0]             valid_row,
  input  logic [WAYS-1:0][TAG_W-1:0]  tag_row,
  input  logic [WAYS-1:0][WI_W-1:0]   rank_row,
  input  logic [TAG_W-1:0]            tag,
  output sacl_outcome_t               outcome,
  output logic [WAYS-1:0]             valid_new,
  output logic [WAYS-1:0][TAG_W-1:0]  tag_new,
  output logic [WAYS-1:0][WI_W-1:0]   rank_new
);

  localparam logic [WI_W-1:0] RANK_MAX = WI_W'(WAYS - 1);

  logic [WAYS-1:0] used;
  logic [WAYS-1:0] hit_vec;
  logic [WAYS-1:0] free_vec;
  logic [WI_W-1:0] hit_way;
  logic [WI_W-1:0] free_way;
  logic [WI_W-1:0] victim;
  logic [WI_W-1:0] best;
  logic            found;
  logic [WI_W-1:0] sel;
  logic [WI_W-1:0] sel_rank;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      used[i]     = WN_W'(i) < n;
      hit_vec[i]  = used[i] & valid_row[i] & (tag_row[i] == tag);
      free_vec[i] = used[i] & ~valid_row[i];
    end
    hit_way  = '0;
    free_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WI_W'(i);
      end
      if (free_vec[i]) begin
        free_way = WI_W'(i);
      end
    end
    victim = '0;
    best   = '0;
    found  = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      if (used[i] && (!found || rank_row[i] > best)) begin
        best   = rank_row[i];
        victim = WI_W'(i);
        found  = 1'b1;
      end
    end
    outcome.hit   = |hit_vec;
    outcome.fill  = ~outcome.hit & (|free_vec);
    outcome.evict = ~outcome.hit & ~outcome.fill;
    sel = outcome.hit ? hit_way : (outcome.fill ? free_way : victim);
    sel_rank = rank_row[sel];
    for (int i = 0; i < WAYS; i++) begin
      valid_new[i] = valid_row[i] | (WI_W'(i) == sel);
      tag_new[i]   = (WI_W'(i) == sel) ? tag : tag_row[i];
      if (WI_W'(i) == sel) begin
        rank_new[i] = '0;
      end else if (used[i] && valid_row[i] && (outcome.fill || rank_row[i] < sel_rank)
                   && rank_row[i] < RANK_MAX) begin
        rank_new[i] = rank_row[i] + 1'b1;
      end else begin
        rank_new[i] = rank_row[i];
      end
    end
  end

endmodule

// File: rtl/set_associative_cache_lru_sim.sv
// ----------------------------------------------------------------------------
// set_associative_cache_lru_sim
// Sequence: an accepted start moves the FSM from IDLE to LOOK, which raises
// busy; LOOK registers done and the results and returns to IDLE.
// Requests: none is taken while busy; the set row is read from RAM when start
// is taken and written back in LOOK, except for CMD_INSTR requests.
// Reset: synchronous; clears valid bits, totals and config (all to one).
// ----------------------------------------------------------------------------
module set_associative_cache_lru_sim
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 4,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              cmd,
  input  logic [ADDRESS_BITS-1:0] address,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [4:0]              cfg_data,
  output logic                    done,
  output logic [1:0]              hits_added,
  output logic                    missed,
  output logic                    evicted,
  output logic [31:0]             hit_total,
  output logic [31:0]             miss_total,
  output logic [31:0]             eviction_total
);

  localparam int SETS      = 1 << MAX_SET_BITS;
  localparam int TAG_W     = ADDRESS_BITS - 2;
  localparam int WI_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WN_W      = $clog2(WAYS + 1);
  localparam int SHW       = $clog2(ADDRESS_BITS) + 1;
  localparam int BMAX      = ADDRESS_BITS - MAX_SET_BITS - 1;
  localparam int ROW_W     = WAYS * (TAG_W + WI_W);

  typedef enum logic {IDLE, LOOK} state_t;

  state_t state;
  logic [2:0] set_bits;
  logic [4:0] block_bits;
  logic [2:0] ways_in_use;

  logic [SHW-1:0]          b_eff;
  logic [SHW-1:0]          s_eff;
  logic [WN_W-1:0]         n_eff;
  logic [MAX_SET_BITS-1:0] set_mask;
  logic [MAX_SET_BITS-1:0] set_idx;
  logic [TAG_W-1:0]        tag_idx;
  logic                    accept;

  sacl_cmd_t               cmd_q;
  logic [MAX_SET_BITS-1:0] set_q;
  logic [TAG_W-1:0]        tag_q;

  logic [WAYS-1:0]         valid_mem [SETS];
  logic [ROW_W-1:0]        row_rd;
  logic [ROW_W-1:0]        row_wr;

  sacl_outcome_t             outcome;
  logic [WAYS-1:0]           valid_new;
  logic [WAYS-1:0][TAG_W-1:0] tag_new;
  logic [WAYS-1:0][WI_W-1:0]  rank_new;

  logic        active;
  logic [1:0]  hits_inc;
  logic        miss_inc;
  logic        evict_inc;
  logic [32:0] hit_sum;
  logic        write_row;

  assign cfg_ready = 1'b1;
  assign busy      = (state == LOOK);
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= 3'd1;
      block_bits  <= 5'd1;
      ways_in_use <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SET_BITS:    set_bits    <= cfg_data[2:0];
        CFG_BLOCK_BITS:  block_bits  <= cfg_data;
        CFG_WAYS_IN_USE: ways_in_use <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (block_bits == '0) begin
      b_eff = SHW'(1);
    end else if (int'(block_bits) > BMAX) begin
      b_eff = SHW'(BMAX);
    end else begin
      b_eff = SHW'(block_bits);
    end
    if (set_bits == '0) begin
      s_eff = SHW'(1);
    end else if (int'(set_bits) > MAX_SET_BITS) begin
      s_eff = SHW'(MAX_SET_BITS);
    end else begin
      s_eff = SHW'(set_bits);
    end
    if (ways_in_use == '0) begin
      n_eff = WN_W'(1);
    end else if (int'(ways_in_use) > WAYS) begin
      n_eff = WN_W'(WAYS);
    end else begin
      n_eff = WN_W'(ways_in_use);
    end
    for (int i = 0; i < MAX_SET_BITS; i++) begin
      set_mask[i] = SHW'(i) < s_eff;
    end
    set_idx = MAX_SET_BITS'(address >> b_eff) & set_mask;
    tag_idx = TAG_W'(address >> (b_eff + s_eff));
  end

  sacl_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SETS)
  ) u_row_ram (
    .clk  (clk),
    .we   (write_row),
    .waddr(set_q),
    .wdata(row_wr),
    .re   (accept),
    .raddr(set_idx),
    .rdata(row_rd)
  );

  sacl_way_sel #(
    .WAYS (WAYS),
    .TAG_W(TAG_W)
  ) u_way_sel (
    .n        (n_eff),
    .valid_row(valid_mem[set_q]),
    .tag_row  (row_rd[WAYS*TAG_W-1:0]),
    .rank_row (row_rd[ROW_W-1:WAYS*TAG_W]),
    .tag      (tag_q),
    .outcome  (outcome),
    .valid_new(valid_new),
    .tag_new  (tag_new),
    .rank_new (rank_new)
  );

  assign row_wr    = {rank_new, tag_new};
  assign active    = (cmd_q != CMD_INSTR);
  assign write_row = busy & active;

  always_comb begin
    hits_inc  = active ? ({1'b0, outcome.hit} + {1'b0, cmd_q == CMD_MODIFY}) : 2'd0;
    miss_inc  = active & ~outcome.hit;
    evict_inc = active & outcome.evict;
    hit_sum   = {1'b0, hit_total} + 33'(hits_inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SETS; i++) begin
        valid_mem[i] <= '0;
      end
    end else if (write_row) begin
      valid_mem[set_q] <= valid_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      done           <= 1'b0;
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            state <= LOOK;
            cmd_q <= sacl_cmd_t'(cmd);
            set_q <= set_idx;
            tag_q <= tag_idx;
          end
        end
        LOOK: begin
          state      <= IDLE;
          done       <= 1'b1;
          hits_added <= hits_inc;
          missed     <= miss_inc;
          evicted    <= evict_inc;
          hit_total  <= hit_sum[32] ? '1 : hit_sum[31:0];
          if (miss_inc && miss_total != '1) begin
            miss_total <= miss_total + 32'd1;
          end
          if (evict_inc && eviction_total != '1) begin
            eviction_total <= eviction_total + 32'd1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: rtl/sacl_checker.sv
// ----------------------------------------------------------------------------
// sacl_checker
// Port-level checks of request timing and result consistency for the
// cache simulator.
// ----------------------------------------------------------------------------
module sacl_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] hits_added,
  input logic       missed,
  input logic       evicted
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("Accepted request did not raise busy.");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("Result did not follow the busy cycle.");

  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    done && evicted |-> missed)
    else $error("Eviction reported without a miss.");

  a_miss_hits: assert property (@(posedge clk) disable iff (rst)
    done && missed |-> (hits_added == 2'd0 || hits_added == 2'd1))
    else $error("Missed request reported two hits.");

endmodule

bind set_associative_cache_lru_sim sacl_checker u_sacl_checker (.*);

// File: dv/tb_set_associative_cache_lru_sim.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_associative_cache_lru_sim
// Self-checking bench for the set-associative cache simulator with LRU
// replacement. Trace requests go in through the start/busy handshake, and
// every strobed result is compared field by field with a behavioral cache
// that tracks valid bits, tags, age ranks and saturating totals. Directed
// tests cover the reset geometry, clamped and ignored register writes and
// the LRU victim order. Random traffic then replays small address pools
// under changing geometries and sender gap rates.
// ----------------------------------------------------------------------------
module tb_set_associative_cache_lru_sim;
  import sacl_pkg::*;

  localparam int MAX_SET_BITS = 6;
  localparam int WAYS = 4;
  localparam int ADDRESS_BITS = 32;
  localparam int NUM_LINES = (1 << MAX_SET_BITS) * WAYS;
  localparam int BLOCK_BITS_MAX = ADDRESS_BITS - MAX_SET_BITS - 1;
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  hits_added;
    logic        missed;
    logic        evicted;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
  } access_stats_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  cmd;
  logic [31:0] address;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [4:0]  cfg_data;
  logic        done;
  logic [1:0]  hits_added;
  logic        missed;
  logic        evicted;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic [31:0] eviction_total;

  set_associative_cache_lru_sim #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .WAYS(WAYS),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .address(address),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .hits_added(hits_added),
    .missed(missed),
    .evicted(evicted),
    .hit_total(hit_total),
    .miss_total(miss_total),
    .eviction_total(eviction_total)
  );

  bit          cached_valid [NUM_LINES];
  logic [31:0] cached_tag [NUM_LINES];
  logic [1:0]  cached_rank [NUM_LINES];
  logic [31:0] hit_tally;
  logic [31:0] miss_tally;
  logic [31:0] evict_count;
  logic [2:0]  set_bits_reg;
  logic [4:0]  block_bits_reg;
  logic [2:0]  ways_reg;

  access_stats_t pending_stats [$];
  int err_count;
  int requests_sent;
  int registers_written;
  int gap_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == COUNT_MAX) ? c : c + 32'd1;
  endfunction

  function automatic void clear_cache_model();
    for (int i = 0; i < NUM_LINES; i++) begin
      cached_valid[i] = 1'b0;
      cached_tag[i] = '0;
      cached_rank[i] = '0;
    end
    hit_tally = '0;
    miss_tally = '0;
    evict_count = '0;
    set_bits_reg = 3'd1;
    block_bits_reg = 5'd1;
    ways_reg = 3'd1;
  endfunction

  // The touched way becomes most recent. Valid ways that were more recent age
  // by one; on a fill every valid way in use below the oldest rank ages.
  function automatic void promote_way(int base, int n, int w, bit was_valid);
    int limit;
    limit = was_valid ? int'(cached_rank[base + w]) : WAYS;
    for (int i = 0; i < n; i++) begin
      if (i != w && cached_valid[base + i] && cached_rank[base + i] < limit
          && cached_rank[base + i] < WAYS - 1)
        cached_rank[base + i] = cached_rank[base + i] + 2'd1;
    end
    cached_rank[base + w] = '0;
  endfunction

  function automatic bit lookup_line(logic [31:0] addr, output bit evict);
    int s;
    int b;
    int n;
    int base;
    int victim;
    logic [31:0] tag;
    logic [1:0] oldest;
    s = clamp(int'(set_bits_reg), 1, MAX_SET_BITS);
    b = clamp(int'(block_bits_reg), 1, BLOCK_BITS_MAX);
    n = clamp(int'(ways_reg), 1, WAYS);
    base = int'((addr >> b) & ((32'd1 << s) - 32'd1)) * WAYS;
    tag = addr >> (b + s);
    evict = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (cached_valid[base + i] && cached_tag[base + i] == tag) begin
        promote_way(base, n, i, 1'b1);
        return 1'b1;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (!cached_valid[base + i]) begin
        promote_way(base, n, i, 1'b0);
        cached_valid[base + i] = 1'b1;
        cached_tag[base + i] = tag;
        return 1'b0;
      end
    end
    victim = 0;
    oldest = cached_rank[base];
    for (int i = 1; i < n; i++) begin
      if (cached_rank[base + i] > oldest) begin
        oldest = cached_rank[base + i];
        victim = i;
      end
    end
    promote_way(base, n, victim, 1'b1);
    cached_tag[base + victim] = tag;
    evict = 1'b1;
    return 1'b0;
  endfunction

  function automatic access_stats_t predict_request(sacl_cmd_t op, logic [31:0] addr);
    access_stats_t r;
    bit ev;
    r = '0;
    if (op != CMD_INSTR) begin
      if (lookup_line(addr, ev)) begin
        r.hits_added = 2'd1;
        hit_tally = sat_inc(hit_tally);
      end else begin
        r.missed = 1'b1;
        miss_tally = sat_inc(miss_tally);
        if (ev) begin
          r.evicted = 1'b1;
          evict_count = sat_inc(evict_count);
        end
      end
      if (op == CMD_MODIFY) begin
        void'(lookup_line(addr, ev));
        r.hits_added = r.hits_added + 2'd1;
        hit_tally = sat_inc(hit_tally);
      end
    end
    r.hit_total = hit_tally;
    r.miss_total = miss_tally;
    r.eviction_total = evict_count;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (act !== exp) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    access_stats_t want;
    if (!rst && done) begin
      if (pending_stats.size() == 0) begin
        $error("result strobe with no request outstanding");
        err_count++;
      end else begin
        want = pending_stats.pop_front();
        check_field("hits_added", 32'(want.hits_added), 32'(hits_added));
        check_field("missed", 32'(want.missed), 32'(missed));
        check_field("evicted", 32'(want.evicted), 32'(evicted));
        check_field("hit_total", want.hit_total, hit_total);
        check_field("miss_total", want.miss_total, miss_total);
        check_field("eviction_total", want.eviction_total, eviction_total);
      end
    end
  end

  task automatic send_request(sacl_cmd_t op, logic [31:0] addr);
    @(negedge clk);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start <= 1'b1;
    cmd <= op;
    address <= addr;
    do @(posedge clk); while (busy);
    pending_stats.push_back(predict_request(op, addr));
    requests_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [4:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SET_BITS: set_bits_reg = data[2:0];
      CFG_BLOCK_BITS: block_bits_reg = data;
      CFG_WAYS_IN_USE: ways_reg = data[2:0];
      default: ;
    endcase
    registers_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_geometry();
    send_request(CMD_INSTR, 32'hFFFF_FFFF);
    send_request(CMD_LOAD, 32'h0000_0000);
    send_request(CMD_LOAD, 32'h0000_0001);
    send_request(CMD_STORE, 32'h0000_0004);
    send_request(CMD_MODIFY, 32'h0000_0000);
    send_request(CMD_LOAD, 32'hFFFF_FFFF);
    send_request(CMD_MODIFY, 32'hFFFF_FFFE);
  endtask

  task automatic test_register_clamping();
    drain_results();
    write_register(CFG_SET_BITS, 5'h1F);
    write_register(CFG_BLOCK_BITS, 5'd31);
    write_register(CFG_WAYS_IN_USE, 5'h1F);
    send_request(CMD_LOAD, 32'hFFFF_FFFF);
    send_request(CMD_LOAD, 32'h7FFF_FFFF);
    send_request(CMD_MODIFY, 32'h8000_0000);
    drain_results();
    write_register(CFG_BLOCK_BITS, 5'd25);
    send_request(CMD_STORE, 32'hFFFF_FFFF);
    drain_results();
    write_register(CFG_UNMAPPED, 5'h1F);
    write_register(CFG_SET_BITS, 5'd0);
    write_register(CFG_BLOCK_BITS, 5'd0);
    write_register(CFG_WAYS_IN_USE, 5'd0);
    send_request(CMD_LOAD, 32'h0000_0002);
    send_request(CMD_LOAD, 32'h0000_0003);
  endtask

  task automatic test_lru_victim_order();
    drain_results();
    write_register(CFG_SET_BITS, 5'd2);
    write_register(CFG_BLOCK_BITS, 5'd4);
    write_register(CFG_WAYS_IN_USE, 5'd4);
    for (int t = 1; t <= 4; t++) send_request(CMD_LOAD, (t << 6) | 32'h10);
    send_request(CMD_LOAD, (1 << 6) | 32'h10);
    send_request(CMD_STORE, (5 << 6) | 32'h1F);
    send_request(CMD_LOAD, (2 << 6) | 32'h10);
    send_request(CMD_MODIFY, (1 << 6) | 32'h13);
    drain_results();
    write_register(CFG_WAYS_IN_USE, 5'd2);
    send_request(CMD_LOAD, (4 << 6) | 32'h10);
    send_request(CMD_LOAD, (3 << 6) | 32'h10);
  endtask

  // Most requests reuse a few tags spread over up to three sets so that hits,
  // fills and evictions all occur; the rest are unconstrained addresses.
  task automatic run_random_phase(int pct, int count);
    logic [31:0] pool [12];
    logic [31:0] addr;
    logic [31:0] offset_mask;
    logic [31:0] index_mask;
    int s;
    int b;
    drain_results();
    write_register(CFG_SET_BITS, 5'($urandom_range(0, 31)));
    write_register(CFG_BLOCK_BITS, 5'($urandom_range(0, 31)));
    write_register(CFG_WAYS_IN_USE, 5'($urandom_range(0, 31)));
    s = clamp(int'(set_bits_reg), 1, MAX_SET_BITS);
    b = clamp(int'(block_bits_reg), 1, BLOCK_BITS_MAX);
    offset_mask = (32'd1 << b) - 32'd1;
    index_mask = (32'd1 << (b + s)) - 32'd1;
    foreach (pool[i])
      pool[i] = ($urandom & ~index_mask) | (32'($urandom_range(0, 2)) << b);
    gap_pct = pct;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 80)
        addr = pool[$urandom_range(0, 11)] | ($urandom & offset_mask);
      else
        addr = $urandom;
      send_request(sacl_cmd_t'($urandom_range(0, 3)), addr);
    end
    gap_pct = 0;
  endtask

  task automatic test_random_traffic();
    int gap_rates [4] = '{0, 64, 0, 27};
    foreach (gap_rates[m]) repeat (2) run_random_phase(gap_rates[m], 60);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_INSTR;
    address = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SET_BITS;
    cfg_data = '0;
    err_count = 0;
    requests_sent = 0;
    registers_written = 0;
    gap_pct = 0;
    clear_cache_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_geometry();
    test_register_clamping();
    test_lru_victim_order();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk);
    $display("Checked %0d requests over %0d register writes, sender gaps 0, 27 and 64 pct.",
             requests_sent, registers_written);
    $display("Model totals: %0d hits, %0d misses, %0d evictions.",
             hit_tally, miss_tally, evict_count);
    if (err_count == 0 && pending_stats.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sacl_pkg.sv
rtl/sacl_ram.sv
rtl/sacl_way_sel.sv
rtl/set_associative_cache_lru_sim.sv
rtl/sacl_checker.sv
dv/tb_set_associative_cache_lru_sim.sv
